// ===== hdl/slsp_pkg.sv =====
// Shared types and constants for the servo lock sequencer and PWM unit.
package slsp_pkg;

  localparam int CH_W     = 4;
  localparam int WIDTH_W  = 10;
  localparam int DELAY_W  = 16;
  localparam int CMD_W    = 8;
  localparam int OP_W     = 3;
  localparam int LEVELS_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int OUT_POWER_BIT = LEVELS_W;
  localparam int OUT_BUSY_BIT  = LEVELS_W + 1;
  localparam int OUT_STATUS_LO = LEVELS_W + 2;

  localparam logic [DELAY_W-1:0] STEP_DELAY_RESET   = 16'd300;
  localparam logic [WIDTH_W-1:0] UNLOCK_WIDTH_RESET = 10'd26;
  localparam logic [WIDTH_W-1:0] LOCK_WIDTH_RESET   = 10'd51;
  localparam logic [WIDTH_W-1:0] PWM_TOP_RESET      = 10'd512;

  localparam logic [CMD_W-1:0] CMD_UNLOCK_ALL = 8'hFF;
  localparam logic [CMD_W-1:0] CMD_LOCK_ALL   = 8'hEE;
  localparam logic [3:0]       CMD_LOCK_HI    = 4'hE;
  localparam logic [3:0]       CMD_UNLOCK_HI  = 4'hF;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP      = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_PWM_TICK = 3'd0,
    OP_MS_TICK  = 3'd1,
    OP_COMMAND  = 3'd2,
    OP_PWM_ON   = 3'd3,
    OP_PWM_OFF  = 3'd4
  } op_t;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic               en;
    logic [CH_W-1:0]    ch;
    logic [WIDTH_W-1:0] width;
  } width_wr_t;

endpackage

// ===== hdl/slsp_pwm.sv =====
// PWM counter, per-channel pulse width store and level compares.
module slsp_pwm import slsp_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [OP_W-1:0]     op,
  input  logic [WIDTH_W-1:0]  pwm_top,
  input  width_wr_t           width_wr,
  output logic [LEVELS_W-1:0] levels_next
);

  logic [WIDTH_W-1:0] widths [CHANNELS];
  logic               enabled;
  logic               enabled_next;
  logic [WIDTH_W-1:0] count;
  logic [WIDTH_W-1:0] count_next;
  logic [WIDTH_W-1:0] cmp_count;
  logic [CHANNELS-1:0] levels;
  logic [CHANNELS-1:0] lv_next;

  always_comb begin
    enabled_next = enabled;
    count_next   = count;
    lv_next      = levels;
    cmp_count    = (count > pwm_top) ? '0 : count;
    case (op_t'(op))
      OP_PWM_TICK: begin
        if (enabled) begin
          for (int i = 0; i < CHANNELS; i++) begin
            lv_next[i] = cmp_count < widths[i];
          end
          count_next = cmp_count + 1'b1;
        end
      end
      OP_PWM_ON: begin
        count_next   = '0;
        enabled_next = 1'b1;
      end
      OP_PWM_OFF: begin
        enabled_next = 1'b0;
        lv_next      = '0;
        count_next   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      count   <= '0;
      levels  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        widths[i] <= UNLOCK_WIDTH_RESET;
      end
    end else begin
      if (fire) begin
        enabled <= enabled_next;
        count   <= count_next;
        levels  <= lv_next;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (width_wr.en && width_wr.ch == CH_W'(i)) begin
          widths[i] <= width_wr.width;
        end
      end
    end
  end

  for (genvar g = 0; g < LEVELS_W; g++) begin : g_lvl
    if (g < CHANNELS) begin : g_on
      assign levels_next[g] = lv_next[g];
    end else begin : g_off
      assign levels_next[g] = 1'b0;
    end
  end

endmodule

// ===== hdl/slsp_seq.sv =====
// Lock/unlock command sequencer: command decode, step delay and power control.
module slsp_seq import slsp_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [OP_W-1:0]    op,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [DELAY_W-1:0] step_delay,
  input  logic [WIDTH_W-1:0] unlock_width,
  input  logic [WIDTH_W-1:0] lock_width,
  output width_wr_t          width_wr,
  output logic               power_next,
  output logic               busy_next,
  output logic [1:0]         status
);

  localparam int SW = $clog2(CHANNELS + 2);
  localparam logic [SW-1:0]   STEP_LAST_ALL = SW'(CHANNELS);
  localparam logic [CH_W-1:0] CH_LAST       = CH_W'(CHANNELS);

  logic               busy;
  logic               power;
  logic               act_all;
  logic               act_lock;
  logic [CH_W-1:0]    act_ch;
  logic [SW-1:0]      step;
  logic [DELAY_W-1:0] delay;

  logic               all_next;
  logic               lock_next;
  logic [CH_W-1:0]    ch_next;
  logic [SW-1:0]      step_next;
  logic [DELAY_W-1:0] delay_next;
  width_wr_t          wr;

  logic            cmd_all;
  logic            cmd_lock;
  logic            cmd_valid;
  logic [3:0]      cmd_hi;
  logic [3:0]      cmd_lo;
  logic [SW-1:0]   step_last;
  logic            in_run;
  logic [CH_W:0]   step_ch;

  always_comb begin
    cmd_hi    = cmd[7:4];
    cmd_lo    = cmd[3:0];
    cmd_all   = (cmd == CMD_UNLOCK_ALL) || (cmd == CMD_LOCK_ALL);
    cmd_lock  = (cmd == CMD_LOCK_ALL) || (cmd_hi == CMD_LOCK_HI);
    cmd_valid = cmd_all || (((cmd_hi == CMD_LOCK_HI) || (cmd_hi == CMD_UNLOCK_HI)) &&
                            (cmd_lo >= 4'd1) && (CH_W'(cmd_lo) <= CH_LAST));
    step_last = act_all ? STEP_LAST_ALL : SW'(1);
    in_run    = (step != '0) && (step <= step_last);
    step_ch   = (CH_W + 1)'(step) - 1'b1;

    busy_next  = busy;
    power_next = power;
    all_next   = act_all;
    lock_next  = act_lock;
    ch_next    = act_ch;
    step_next  = step;
    delay_next = delay;
    status     = STATUS_NONE;
    wr         = '0;

    case (op_t'(op))
      OP_MS_TICK: begin
        if (busy) begin
          if (delay > DELAY_W'(1)) begin
            delay_next = delay - 1'b1;
          end else if (in_run) begin
            wr.en      = 1'b1;
            wr.ch      = act_all ? step_ch[CH_W-1:0] : act_ch;
            wr.width   = act_lock ? lock_width : unlock_width;
            step_next  = step + 1'b1;
            delay_next = step_delay;
          end else begin
            power_next = 1'b0;
            busy_next  = 1'b0;
            step_next  = '0;
            all_next   = 1'b0;
            lock_next  = 1'b0;
            ch_next    = '0;
            delay_next = '0;
          end
        end
      end
      OP_COMMAND: begin
        if (busy) begin
          status = STATUS_BUSY;
        end else if (!cmd_valid) begin
          status = STATUS_UNKNOWN;
        end else begin
          status     = STATUS_ACCEPTED;
          busy_next  = 1'b1;
          power_next = 1'b1;
          all_next   = cmd_all;
          lock_next  = cmd_lock;
          ch_next    = CH_W'(cmd_lo - 1'b1);
          step_next  = SW'(1);
          delay_next = step_delay;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      power    <= 1'b0;
      act_all  <= 1'b0;
      act_lock <= 1'b0;
      act_ch   <= '0;
      step     <= '0;
      delay    <= '0;
    end else if (fire) begin
      busy     <= busy_next;
      power    <= power_next;
      act_all  <= all_next;
      act_lock <= lock_next;
      act_ch   <= ch_next;
      step     <= step_next;
      delay    <= delay_next;
    end
  end

  always_comb begin
    width_wr    = wr;
    width_wr.en = wr.en && fire;
  end

endmodule

// ===== hdl/servo_lock_sequencer_pwm_unit.sv =====
// Top level of the servo lock sequencer and six-channel PWM unit.
//
// Input stream s_*: s_tuser carries the op (PWM tick, ms tick, command,
// PWM enable, PWM disable), s_tdata the command byte. Every input transfer
// produces exactly one result on m_*: channel levels, actuator power, busy
// and command status.
// Each transfer lands in an input register; when the output register is free,
// the sequencer and PWM state update and the result is written to the output
// register. One item is taken per cycle while the output is not stalled by
// m_tready; the rate is set by the single update of the state registers.
// When m_tready is low the output register holds its result, the input
// register still takes one more item, and s_tready drops only once both
// are full. Reset clears all state to its power-up values (PWM off, power
// off, all pulse widths at the unlock width) and empties both registers.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while idle (not enforced).
module servo_lock_sequencer_pwm_unit import slsp_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [CMD_W-1:0]       s_tdata,  // [7:0] command
  input  logic [OP_W-1:0]        s_tuser,  // [2:0] op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // [5:0] pwm_levels, [6] power_on,
                                           // [7] busy_res, [9:8] status
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DELAY_W-1:0] step_delay;
  logic [WIDTH_W-1:0] unlock_width;
  logic [WIDTH_W-1:0] lock_width;
  logic [WIDTH_W-1:0] pwm_top;

  logic             in_valid;
  logic [OP_W-1:0]  in_op;
  logic [CMD_W-1:0] in_cmd;
  logic             fire;

  width_wr_t           width_wr;
  logic                power_next;
  logic                busy_next;
  logic [1:0]          status;
  logic [LEVELS_W-1:0] levels_next;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay   <= STEP_DELAY_RESET;
      unlock_width <= UNLOCK_WIDTH_RESET;
      lock_width   <= LOCK_WIDTH_RESET;
      pwm_top      <= PWM_TOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_DELAY:   step_delay   <= cfg_data;
        CFG_UNLOCK_WIDTH: unlock_width <= cfg_data[WIDTH_W-1:0];
        CFG_LOCK_WIDTH:   lock_width   <= cfg_data[WIDTH_W-1:0];
        CFG_PWM_TOP:      pwm_top      <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_cmd <= s_tdata;
    end
  end

  slsp_seq #(
    .CHANNELS(CHANNELS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .op           (in_op),
    .cmd          (in_cmd),
    .step_delay   (step_delay),
    .unlock_width (unlock_width),
    .lock_width   (lock_width),
    .width_wr     (width_wr),
    .power_next   (power_next),
    .busy_next    (busy_next),
    .status       (status)
  );

  slsp_pwm #(
    .CHANNELS(CHANNELS)
  ) u_pwm (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (in_op),
    .pwm_top     (pwm_top),
    .width_wr    (width_wr),
    .levels_next (levels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {(OUT_TDATA_W - OUT_STATUS_LO - 2)'(0), status, busy_next, power_next,
                  levels_next};
    end
  end

endmodule

// ===== hdl/slsp_check.sv =====
// Port-level assertions for the servo lock sequencer and PWM unit, with bind.
module slsp_check import slsp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic       power;
  logic       busy;
  logic [1:0] status;

  assign power  = m_tdata[OUT_POWER_BIT];
  assign busy   = m_tdata[OUT_BUSY_BIT];
  assign status = m_tdata[OUT_STATUS_LO +: 2];

  a_power_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> power == busy)
    else $error("power_on differs from busy_res");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == STATUS_ACCEPTED) |-> busy)
    else $error("accepted command without busy");

  a_ignored_only_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == STATUS_BUSY) |-> busy)
    else $error("ignored-busy status while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind servo_lock_sequencer_pwm_unit slsp_check u_slsp_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
